### rtl/spba_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 128-bit packed byte ALU.
// Used by the top level and the datapath core; no dependencies.
package spba_pkg;

  localparam int unsigned VEC_BYTES   = 16;
  localparam int unsigned VEC_W       = 8 * VEC_BYTES;
  localparam int unsigned IN_TDATA_W  = 280;
  localparam int unsigned OUT_TDATA_W = 144;

  localparam logic [4:0] MODE_AND    = 5'd0;
  localparam logic [4:0] MODE_OR     = 5'd1;
  localparam logic [4:0] MODE_XOR    = 5'd2;
  localparam logic [4:0] MODE_NOT    = 5'd3;
  localparam logic [4:0] MODE_ANDN   = 5'd4;
  localparam logic [4:0] MODE_EQ     = 5'd5;
  localparam logic [4:0] MODE_NE     = 5'd6;
  localparam logic [4:0] MODE_GT     = 5'd7;
  localparam logic [4:0] MODE_GE     = 5'd8;
  localparam logic [4:0] MODE_LT     = 5'd9;
  localparam logic [4:0] MODE_LE     = 5'd10;
  localparam logic [4:0] MODE_SHL8   = 5'd11;
  localparam logic [4:0] MODE_SHL16  = 5'd12;
  localparam logic [4:0] MODE_SHL32  = 5'd13;
  localparam logic [4:0] MODE_SHL64  = 5'd14;
  localparam logic [4:0] MODE_SHLB   = 5'd15;
  localparam logic [4:0] MODE_SHR8   = 5'd16;
  localparam logic [4:0] MODE_SHR16  = 5'd17;
  localparam logic [4:0] MODE_SHR32  = 5'd18;
  localparam logic [4:0] MODE_SHR64  = 5'd19;
  localparam logic [4:0] MODE_SHRB   = 5'd20;
  localparam logic [4:0] MODE_ALIGNR = 5'd21;
  localparam logic [4:0] MODE_SHUF   = 5'd22;
  localparam logic [4:0] MODE_SHUFZ  = 5'd23;
  localparam logic [4:0] MODE_SHUFL  = 5'd24;
  localparam logic [4:0] MODE_SPL8   = 5'd25;
  localparam logic [4:0] MODE_SPL16  = 5'd26;
  localparam logic [4:0] MODE_SPL32  = 5'd27;
  localparam logic [4:0] MODE_SPL64  = 5'd28;

  // One operation as held in the input register, first field in the top bits.
  typedef struct packed {
    logic signed [7:0] offset;
    logic [7:0]        count;
    logic [4:0]        mode;
    logic [63:0]       b_hi;
    logic [63:0]       b_lo;
    logic [63:0]       a_hi;
    logic [63:0]       a_lo;
  } spba_req_t;

endpackage

### rtl/spba_core.sv
`timescale 1ns / 1ps
// Combinational datapath of the packed byte ALU: logic, compares, shifts,
// alignment, shuffles and broadcast. Depends on spba_pkg.
module spba_core (
  input  spba_pkg::spba_req_t          req_i,
  output logic [spba_pkg::VEC_W-1:0]   res_o,
  output logic [spba_pkg::VEC_BYTES-1:0] mask_o
);
  import spba_pkg::*;

  // Per-lane keep mask for a logical shift by n within lanes of 8 << sel bits.
  function automatic logic [63:0] lane_keep(input logic [1:0] sel, input logic [5:0] n,
                                            input logic left);
    logic [63:0] m;
    logic [6:0]  w;
    logic [5:0]  p;
    w = 7'd8 << sel;
    for (int j = 0; j < 64; j++) begin
      p = 6'(j) & 6'(w - 7'd1);
      if (left) begin
        m[j] = (p >= n);
      end else begin
        m[j] = ({1'b0, p} + {1'b0, n}) < w;
      end
    end
    return m;
  endfunction

  logic [VEC_W-1:0] a_v, b_v, cmp_v, lane_v, shuf_v, res;
  logic             lane_left;
  logic [1:0]       lane_sel;
  logic [7:0]       lane_w;
  logic [63:0]      lane_m, sh_lo, sh_hi;
  logic             off_ok, len_ok;

  assign a_v = {req_i.a_hi, req_i.a_lo};
  assign b_v = {req_i.b_hi, req_i.b_lo};

  // Byte compares, 0xFF where true.
  always_comb begin
    logic [7:0] ab, bb;
    logic       t;
    cmp_v = '0;
    for (int i = 0; i < VEC_BYTES; i++) begin
      ab = a_v[8*i +: 8];
      bb = b_v[8*i +: 8];
      unique case (req_i.mode)
        MODE_EQ: t = (ab == bb);
        MODE_NE: t = (ab != bb);
        MODE_GT: t = ($signed(ab) >  $signed(bb));
        MODE_GE: t = ($signed(ab) >= $signed(bb));
        MODE_LT: t = ($signed(ab) <  $signed(bb));
        default: t = ($signed(ab) <= $signed(bb));
      endcase
      cmp_v[8*i +: 8] = {8{t}};
    end
  end

  // Lane shifts share one shifter per half; the lane mask removes bits that
  // crossed a lane boundary.
  assign lane_left = (req_i.mode <= MODE_SHLB);
  assign lane_sel  = lane_left ? 2'(req_i.mode - MODE_SHL8) : 2'(req_i.mode - MODE_SHR8);
  assign lane_w    = 8'd8 << lane_sel;
  assign lane_m    = lane_keep(lane_sel, req_i.count[5:0], lane_left);
  assign sh_lo     = lane_left ? (req_i.a_lo << req_i.count[5:0])
                               : (req_i.a_lo >> req_i.count[5:0]);
  assign sh_hi     = lane_left ? (req_i.a_hi << req_i.count[5:0])
                               : (req_i.a_hi >> req_i.count[5:0]);
  assign lane_v    = (req_i.count < lane_w) ? {sh_hi & lane_m, sh_lo & lane_m} : '0;

  assign off_ok = !req_i.offset[7] && (req_i.offset[6:0] <= 7'd16);
  // The masked shuffle keeps bytes below count, and nothing when count exceeds 16.
  assign len_ok = (req_i.count <= 8'd16);

  always_comb begin
    logic [7:0] idx, v;
    shuf_v = '0;
    for (int i = 0; i < VEC_BYTES; i++) begin
      idx = b_v[8*i +: 8];
      v   = a_v[{idx[3:0], 3'b000} +: 8];
      if (req_i.mode != MODE_SHUF && idx[7]) begin
        v = 8'h00;
      end
      if (req_i.mode == MODE_SHUFL && !(len_ok && (8'(i) < req_i.count))) begin
        v = 8'h00;
      end
      shuf_v[8*i +: 8] = v;
    end
  end

  always_comb begin
    logic [2*VEC_W-1:0] cat;
    cat = {a_v, b_v} >> {req_i.offset[4:0], 3'b000};
    res = '0;
    unique case (req_i.mode)
      MODE_AND:  res = a_v & b_v;
      MODE_OR:   res = a_v | b_v;
      MODE_XOR:  res = a_v ^ b_v;
      MODE_NOT:  res = ~a_v;
      MODE_ANDN: res = ~a_v & b_v;
      MODE_EQ, MODE_NE, MODE_GT, MODE_GE, MODE_LT, MODE_LE: res = cmp_v;
      MODE_SHL8, MODE_SHL16, MODE_SHL32, MODE_SHL64,
      MODE_SHR8, MODE_SHR16, MODE_SHR32, MODE_SHR64: res = lane_v;
      MODE_SHLB: begin
        if (req_i.count < 8'd16) res = a_v << {req_i.count[3:0], 3'b000};
      end
      MODE_SHRB: begin
        if (req_i.count < 8'd16) res = a_v >> {req_i.count[3:0], 3'b000};
      end
      MODE_ALIGNR: begin
        if (off_ok) res = cat[VEC_W-1:0];
      end
      MODE_SHUF, MODE_SHUFZ, MODE_SHUFL: res = shuf_v;
      MODE_SPL8:  res = {16{req_i.a_lo[7:0]}};
      MODE_SPL16: res = {8{req_i.a_lo[15:0]}};
      MODE_SPL32: res = {4{req_i.a_lo[31:0]}};
      MODE_SPL64: res = {2{req_i.a_lo}};
      default:    res = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < VEC_BYTES; i++) begin
      mask_o[i] = res[8*i + 7];
    end
  end

  assign res_o = res;

endmodule

### rtl/simd128_packed_byte_alu.sv
`timescale 1ns / 1ps
// Path: an accepted operation waits in the input register, the core works on it
// combinationally, and its result is offered from the result register.
// Throughput: one operation per cycle while results are taken; the output
// register lets a new transaction enter while a finished result still waits.
// The pipeline depth is set by the input register and the result register.
// Reset (rst_ni low, asynchronous) empties both stages; payload is not reset.
module simd128_packed_byte_alu (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // a_lo[63:0], a_hi[127:64], b_lo[191:128], b_hi[255:192], mode[260:256],
  // count[268:261], offset[276:269], zero pad[279:277]
  input  logic [spba_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // result_lo[63:0], result_hi[127:64], byte_mask[143:128]
  output logic [spba_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import spba_pkg::*;

  logic                   in_vld_q, out_vld_q;
  logic                   in_en, out_en;
  spba_req_t              in_q;
  logic [VEC_W-1:0]       res;
  logic [VEC_BYTES-1:0]   msk;
  logic [OUT_TDATA_W-1:0] out_q;

  assign out_en        = !out_vld_q || m_axis_tready;
  assign in_en         = !in_vld_q || out_en;
  assign s_axis_tready = in_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_en) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_en) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en && s_axis_tvalid) begin
      in_q <= spba_req_t'(s_axis_tdata[$bits(spba_req_t)-1:0]);
    end
    if (out_en && in_vld_q) begin
      out_q <= {msk, res};
    end
  end

  spba_core u_core (
    .req_i  (in_q),
    .res_o  (res),
    .mask_o (msk)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

### rtl/spba_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the packed byte ALU, bound to the top level.
// Depends on spba_pkg for the stream widths.
module spba_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [spba_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [spba_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import spba_pkg::*;

  logic [VEC_BYTES-1:0] exp_mask;

  always_comb begin
    for (int i = 0; i < VEC_BYTES; i++) begin
      exp_mask[i] = m_axis_tdata[8*i + 7];
    end
  end

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The input side only stalls when a result is waiting.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with an empty output stage");

  // An accepted operation reaches the output when the sink is ready.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after two cycles");

  // While a result is offered, the byte mask mirrors the sign bits of the result bytes.
  a_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:VEC_W] == exp_mask)
    else $error("byte mask does not match result bytes");

  // Nothing is offered in the cycle reset is released.
  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result offered straight after reset");

endmodule

bind simd128_packed_byte_alu spba_checker u_spba_checker (.*);

### tb/simd128_packed_byte_alu_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for simd128_packed_byte_alu: directed and random operations
// are compared against a behavioural model of the ALU. Depends on spba_pkg and the RTL only.
module simd128_packed_byte_alu_tb;
  import spba_pkg::*;

  // Fields of one result, highest bits first as on m_axis_tdata.
  typedef struct packed {
    logic [15:0] byte_mask;
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } alu_res_t;

  typedef struct packed {
    logic      drain_first;
    spba_req_t op;
  } backlog_entry_t;

  localparam int RANDOM_OPS = 1500;
  localparam int CALM_TAIL  = 200;
  localparam int MAX_SHOWN  = 10;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  backlog_entry_t op_backlog[$];
  alu_res_t       pending_results[$];
  int             total_ops;
  int             results_checked;
  int             error_count;
  int             send_gap;
  int             recv_stall;

  simd128_packed_byte_alu uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic alu_res_t packed_alu_result(spba_req_t op);
    logic [127:0] av;
    logic [127:0] bv;
    logic [127:0] rv;
    logic [7:0]   ab;
    logic [7:0]   bb;
    logic         hit;
    int           cnt;
    int           off;
    int           w;
    int           p;
    int           s;
    int           keep;
    alu_res_t     res;
    av  = {op.a_hi, op.a_lo};
    bv  = {op.b_hi, op.b_lo};
    rv  = '0;
    cnt = op.count;
    off = op.offset;
    case (op.mode)
      MODE_AND:  rv = av & bv;
      MODE_OR:   rv = av | bv;
      MODE_XOR:  rv = av ^ bv;
      MODE_NOT:  rv = ~av;
      MODE_ANDN: rv = ~av & bv;
      MODE_EQ, MODE_NE, MODE_GT, MODE_GE, MODE_LT, MODE_LE: begin
        for (int i = 0; i < 16; i++) begin
          ab = av[8*i +: 8];
          bb = bv[8*i +: 8];
          case (op.mode)
            MODE_EQ: hit = (ab == bb);
            MODE_NE: hit = (ab != bb);
            MODE_GT: hit = ($signed(ab) > $signed(bb));
            MODE_GE: hit = ($signed(ab) >= $signed(bb));
            MODE_LT: hit = ($signed(ab) < $signed(bb));
            default: hit = ($signed(ab) <= $signed(bb));
          endcase
          rv[8*i +: 8] = hit ? 8'hFF : 8'h00;
        end
      end
      MODE_SHL8, MODE_SHL16, MODE_SHL32, MODE_SHL64: begin
        w = 8 << (op.mode - MODE_SHL8);
        if (cnt < w) begin
          for (int j = 0; j < 128; j++) begin
            p = j % w;
            if (p >= cnt) rv[j] = av[j - cnt];
          end
        end
      end
      MODE_SHR8, MODE_SHR16, MODE_SHR32, MODE_SHR64: begin
        w = 8 << (op.mode - MODE_SHR8);
        if (cnt < w) begin
          for (int j = 0; j < 128; j++) begin
            p = j % w;
            if (p + cnt < w) rv[j] = av[j + cnt];
          end
        end
      end
      MODE_SHLB, MODE_SHRB: begin
        if (cnt < 16) begin
          for (int i = 0; i < 16; i++) begin
            s = (op.mode == MODE_SHLB) ? i - cnt : i + cnt;
            if (s >= 0 && s < 16) rv[8*i +: 8] = av[8*s +: 8];
          end
        end
      end
      MODE_ALIGNR: begin
        // The source is the 32-byte string with B in the low half and A above it.
        if (off >= 0 && off <= 16) begin
          for (int i = 0; i < 16; i++) begin
            s = i + off;
            rv[8*i +: 8] = (s < 16) ? bv[8*s +: 8] : av[8*(s-16) +: 8];
          end
        end
      end
      MODE_SHUF, MODE_SHUFZ, MODE_SHUFL: begin
        // The masked length is an 8-bit count, so anything past sixteen clears all.
        keep = 16;
        if (op.mode == MODE_SHUFL) keep = (cnt <= 16) ? cnt : 0;
        for (int i = 0; i < 16; i++) begin
          ab = bv[8*i +: 8];
          if (op.mode != MODE_SHUF && ab[7]) rv[8*i +: 8] = 8'h00;
          else rv[8*i +: 8] = av[8*ab[3:0] +: 8];
          if (i >= keep) rv[8*i +: 8] = 8'h00;
        end
      end
      MODE_SPL8, MODE_SPL16, MODE_SPL32, MODE_SPL64: begin
        w = 8 << (op.mode - MODE_SPL8);
        for (int j = 0; j < 128; j++) rv[j] = op.a_lo[j % w];
      end
      default: rv = '0;
    endcase
    res.result_lo = rv[63:0];
    res.result_hi = rv[127:64];
    for (int i = 0; i < 16; i++) res.byte_mask[i] = rv[8*i + 7];
    return res;
  endfunction

  function automatic spba_req_t make_op(logic [4:0] mode, logic [7:0] count,
                                        logic [7:0] offset, logic [63:0] a_lo,
                                        logic [63:0] a_hi, logic [63:0] b_lo,
                                        logic [63:0] b_hi);
    spba_req_t op;
    op.mode   = mode;
    op.count  = count;
    op.offset = offset;
    op.a_lo   = a_lo;
    op.a_hi   = a_hi;
    op.b_lo   = b_lo;
    op.b_hi   = b_hi;
    return op;
  endfunction

  function automatic logic [63:0] random_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {8{8'h80}};
      3:       return {8{8'h7f}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic spba_req_t random_op();
    spba_req_t op;
    int        w;
    op.a_lo = random_word();
    op.a_hi = random_word();
    op.b_lo = random_word();
    op.b_hi = random_word();
    if ($urandom_range(0, 19) == 0) op.mode = 5'($urandom_range(29, 31));
    else op.mode = 5'($urandom_range(0, 28));
    op.count  = 8'($urandom_range(0, 255));
    op.offset = 8'($urandom_range(0, 255));
    case (op.mode)
      MODE_EQ, MODE_NE, MODE_GT, MODE_GE, MODE_LT, MODE_LE: begin
        // Mostly equal operands so that ties and near misses turn up per byte.
        if ($urandom_range(0, 2) == 0) begin
          op.b_lo = op.a_lo ^ (64'($urandom_range(0, 255)) << (8 * $urandom_range(0, 7)));
          op.b_hi = op.a_hi;
        end
      end
      MODE_SHL8, MODE_SHL16, MODE_SHL32, MODE_SHL64,
      MODE_SHR8, MODE_SHR16, MODE_SHR32, MODE_SHR64: begin
        w = (op.mode <= MODE_SHL64) ? 8 << (op.mode - MODE_SHL8) : 8 << (op.mode - MODE_SHR8);
        if ($urandom_range(0, 3) != 0) op.count = 8'($urandom_range(0, w + 1));
      end
      MODE_SHLB, MODE_SHRB, MODE_SHUFL: begin
        if ($urandom_range(0, 3) != 0) op.count = 8'($urandom_range(0, 18));
      end
      default: ;
    endcase
    if (op.mode == MODE_ALIGNR && $urandom_range(0, 3) != 0)
      op.offset = 8'($urandom_range(0, 20) - 2);
    if (op.mode >= MODE_SHUF && op.mode <= MODE_SHUFL && $urandom_range(0, 1) == 0) begin
      op.b_lo &= {8{8'h7f}};
      op.b_hi &= {8{8'h7f}};
    end
    return op;
  endfunction

  task automatic queue_op(spba_req_t op, logic drain_first);
    backlog_entry_t e;
    e.op          = op;
    e.drain_first = drain_first;
    op_backlog.push_back(e);
  endtask

  task automatic report_mismatch(string field, logic [63:0] exp_v, logic [63:0] act_v);
    error_count++;
    if (error_count <= MAX_SHOWN)
      $display("mismatch in %s of result %0d: expected %h, got %h",
               field, results_checked, exp_v, act_v);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Sender: one transaction per handshake, with random gaps until the tail of the run.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(packed_alu_result(spba_req_t'(s_axis_tdata[276:0])));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap == 0 && op_backlog.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
          send_gap = $urandom_range(1, 17);
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (op_backlog.size() > 0 &&
                     !(op_backlog[0].drain_first && pending_results.size() != 0)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b000, op_backlog[0].op};
          void'(op_backlog.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transaction and stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin
    alu_res_t got;
    alu_res_t exp_r;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = alu_res_t'(m_axis_tdata);
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_SHOWN)
            $display("unexpected result: %h", m_axis_tdata);
        end else begin
          exp_r = pending_results.pop_front();
          if (got.result_lo !== exp_r.result_lo)
            report_mismatch("result_lo", exp_r.result_lo, got.result_lo);
          if (got.result_hi !== exp_r.result_hi)
            report_mismatch("result_hi", exp_r.result_hi, got.result_hi);
          if (got.byte_mask !== exp_r.byte_mask)
            report_mismatch("byte_mask", 64'(exp_r.byte_mask), 64'(got.byte_mask));
        end
        results_checked++;
      end
      if (recv_stall == 0 && results_checked < total_ops - CALM_TAIL &&
          $urandom_range(0, 9) == 0)
        recv_stall = $urandom_range(1, 17);
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [63:0] a_lo;
    logic [63:0] a_hi;
    logic [63:0] b_lo;
    logic [63:0] b_hi;
    logic [63:0] ctl_lo;
    logic [63:0] ctl_hi;
    results_checked = 0;
    error_count     = 0;
    a_lo   = 64'h8877_6655_4433_2211;
    a_hi   = 64'h00ff_eedd_ccbb_aa99;
    b_lo   = 64'h7f80_0001_4433_81fe;
    b_hi   = 64'h0123_4567_ccbb_cdef;
    ctl_lo = 64'h8f0e_0d0c_0b0a_0900;
    ctl_hi = 64'h0706_0504_0302_81ff;

    // Bitwise logic and every compare on mixed operands with some equal bytes.
    for (int m = MODE_AND; m <= MODE_LE; m++)
      queue_op(make_op(5'(m), 8'd0, 8'd0, a_lo, a_hi, b_lo, b_hi), 1'b0);
    // Signed extremes: 0x80 against 0x7f both ways round.
    queue_op(make_op(MODE_GT, 8'd0, 8'd0, {8{8'h80}}, {8{8'h7f}}, {8{8'h7f}}, {8{8'h80}}), 1'b0);
    // Shifts at one below and at the lane or vector width, and a one-bit 64-bit shift.
    queue_op(make_op(MODE_SHL8, 8'd7, 8'd0, a_lo, a_hi, b_lo, b_hi), 1'b0);
    queue_op(make_op(MODE_SHR8, 8'd8, 8'd0, '1, '1, b_lo, b_hi), 1'b0);
    queue_op(make_op(MODE_SHL16, 8'd16, 8'd0, '1, '1, b_lo, b_hi), 1'b0);
    queue_op(make_op(MODE_SHR32, 8'd31, 8'd0, '1, '1, b_lo, b_hi), 1'b0);
    queue_op(make_op(MODE_SHL64, 8'd64, 8'd0, '1, '1, b_lo, b_hi), 1'b0);
    queue_op(make_op(MODE_SHR64, 8'd1, 8'd0, a_lo, a_hi, b_lo, b_hi), 1'b0);
    queue_op(make_op(MODE_SHLB, 8'd16, 8'd0, a_lo, a_hi, b_lo, b_hi), 1'b0);
    queue_op(make_op(MODE_SHRB, 8'd15, 8'd0, a_lo, a_hi, b_lo, b_hi), 1'b0);
    // Alignment: whole B, whole A, and offsets just outside the range.
    queue_op(make_op(MODE_ALIGNR, 8'd0, 8'd0, a_lo, a_hi, b_lo, b_hi), 1'b0);
    queue_op(make_op(MODE_ALIGNR, 8'd0, 8'd16, a_lo, a_hi, b_lo, b_hi), 1'b0);
    queue_op(make_op(MODE_ALIGNR, 8'd0, 8'd17, a_lo, a_hi, b_lo, b_hi), 1'b0);
    queue_op(make_op(MODE_ALIGNR, 8'd0, 8'hff, a_lo, a_hi, b_lo, b_hi), 1'b0);
    // Shuffles with control bytes that have the top bit set, and masked lengths.
    queue_op(make_op(MODE_SHUF, 8'd0, 8'd0, a_lo, a_hi, ctl_lo, ctl_hi), 1'b0);
    queue_op(make_op(MODE_SHUFZ, 8'd0, 8'd0, a_lo, a_hi, ctl_lo, ctl_hi), 1'b0);
    queue_op(make_op(MODE_SHUFL, 8'd0, 8'd0, a_lo, a_hi, ctl_lo, ctl_hi), 1'b0);
    queue_op(make_op(MODE_SHUFL, 8'd16, 8'd0, a_lo, a_hi, ctl_lo, ctl_hi), 1'b0);
    queue_op(make_op(MODE_SHUFL, 8'd17, 8'd0, a_lo, a_hi, ctl_lo, ctl_hi), 1'b0);
    queue_op(make_op(MODE_SPL8, 8'd0, 8'd0, a_lo, a_hi, b_lo, b_hi), 1'b0);
    queue_op(make_op(MODE_SPL64, 8'd0, 8'd0, a_lo, a_hi, b_lo, b_hi), 1'b0);
    // An unused mode must give an all-zero result.
    queue_op(make_op(5'd31, 8'hff, 8'h7f, '1, '1, '1, '1), 1'b0);

    // The random part starts on an empty pipeline, and drains once more half way.
    for (int n = 0; n < RANDOM_OPS; n++)
      queue_op(random_op(), (n == 0) || (n == RANDOM_OPS / 2));
    total_ops = op_backlog.size();

    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (op_backlog.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
